>>> rtl/dwne_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dwne_pkg
// Shared constants, types and saturation helpers of the damped weighted
// normal-equation builder.
// ----------------------------------------------------------------------------
package dwne_pkg;

    localparam int MAX_COLS = 8;
    localparam int IDX_W    = $clog2(MAX_COLS);
    localparam int CNT_W    = $clog2(MAX_COLS + 1);
    localparam int ELEM_W   = 32;
    localparam int ACC_W    = 48;
    localparam int NORM_W   = 64;
    localparam int ROOT_W   = 40;
    localparam int STEP_W   = 4;

    // Issue steps: one per matrix row, then the right side, then damping.
    localparam logic [STEP_W-1:0] STEP_RHS  = STEP_W'(MAX_COLS);
    localparam logic [STEP_W-1:0] STEP_DAMP = STEP_W'(MAX_COLS + 1);

    localparam int DRAIN_CYC = 4;

    // Configuration register indexes.
    localparam logic CFG_DAMPING = 1'b0;
    localparam logic CFG_COLS    = 1'b1;

    localparam logic signed [ACC_W-1:0] S48_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] S48_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic             v;
        logic             sub;   // right-side term: subtract
        logic [IDX_W-1:0] addr;
    } t_tag;

    typedef struct packed {
        logic signed [ELEM_W-1:0] a;
        logic signed [ELEM_W-1:0] b;
        logic [ELEM_W-1:0]        f;
        t_tag                     tag;
    } t_op;

    // Sign and magnitude to a saturated 48-bit term.
    function automatic logic signed [ACC_W-1:0] sat_term(input logic [NORM_W-1:0] mag,
                                                         input logic neg);
        logic signed [ACC_W-1:0] res;
        if (neg) begin
            if (mag > {{(NORM_W-ACC_W){1'b0}}, S48_MIN}) res = S48_MIN;
            else res = -$signed(mag[ACC_W-1:0]);
        end else begin
            if (mag > {{(NORM_W-ACC_W){1'b0}}, S48_MAX}) res = S48_MAX;
            else res = $signed(mag[ACC_W-1:0]);
        end
        return res;
    endfunction

    function automatic logic signed [ACC_W-1:0] add_sat(input logic signed [ACC_W-1:0] a,
                                                        input logic signed [ACC_W-1:0] b,
                                                        input logic sub);
        logic signed [ACC_W+1:0] s;
        logic signed [ACC_W-1:0] res;
        if (sub) s = (ACC_W+2)'(a) - (ACC_W+2)'(b);
        else s = (ACC_W+2)'(a) + (ACC_W+2)'(b);
        if (s > (ACC_W+2)'(S48_MAX)) res = S48_MAX;
        else if (s < (ACC_W+2)'(S48_MIN)) res = S48_MIN;
        else res = s[ACC_W-1:0];
        return res;
    endfunction

endpackage
`default_nettype wire

>>> rtl/damped_weighted_normal_equations_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// damped_weighted_normal_equations_top
// Accumulates sum w*J^T*J, -sum w*J*r and sum w*r^2 over streamed rows and
// emits the damped normal system one matrix row per result.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a transaction is taken at a clock edge with start high and busy
//   low. Mode 0 carries a Jacobian row; mode 1 loads the damping diagonal
//   and is absorbed at once (busy stays low).
//   A row occupies the eight column lanes for its issue steps (one per
//   matrix row, one for the right side, one for damping); busy stays high
//   through them, so a new row is taken only once the last one is issued.
//   On a row with last_row set the block waits for the lanes to
//   drain, runs a bit-serial square root for residual_norm, then
//   sweeps over the accumulators: one result per column in use,
//   each on the ports for one cycle with o_result_valid, o_last on the
//   final one. The sweep clears the accumulators.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
//   (0 damping, 1 columns in use) at once; write only while busy is low.
//   Reset (synchronous, i_rst_n low) clears accumulators, loads the damping
//   diagonal with ones, damping with zero and columns in use with eight.
//   Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module damped_weighted_normal_equations_top
    import dwne_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic                    i_cfg_we,
    input  wire logic                    i_cfg_idx,
    input  wire logic [31:0]             i_cfg_data,
    input  wire logic                    i_mode,
    input  wire logic signed [31:0]      i_elem_0,
    input  wire logic signed [31:0]      i_elem_1,
    input  wire logic signed [31:0]      i_elem_2,
    input  wire logic signed [31:0]      i_elem_3,
    input  wire logic signed [31:0]      i_elem_4,
    input  wire logic signed [31:0]      i_elem_5,
    input  wire logic signed [31:0]      i_elem_6,
    input  wire logic signed [31:0]      i_elem_7,
    input  wire logic signed [31:0]      i_residual,
    input  wire logic [31:0]             i_weight,
    input  wire logic                    i_last_row,
    output logic                         o_result_valid,
    output logic signed [47:0]           o_mat_0,
    output logic signed [47:0]           o_mat_1,
    output logic signed [47:0]           o_mat_2,
    output logic signed [47:0]           o_mat_3,
    output logic signed [47:0]           o_mat_4,
    output logic signed [47:0]           o_mat_5,
    output logic signed [47:0]           o_mat_6,
    output logic signed [47:0]           o_mat_7,
    output logic signed [47:0]           o_rhs_entry,
    output logic signed [47:0]           o_gradient_entry,
    output logic [39:0]                  o_residual_norm,
    output logic                         o_last
);

    typedef enum logic [2:0] {S_IDLE, S_RUN, S_DRAIN, S_ROOT, S_EMIT} t_state;

    t_state                   r_state;
    logic [STEP_W-1:0]        r_step;
    logic [IDX_W-1:0]         r_k;
    logic [2:0]               r_drain;
    logic [31:0]              r_damping;
    logic [3:0]               r_cols_cfg;
    logic [CNT_W-1:0]         r_cols;
    logic                     r_last;
    logic signed [ELEM_W-1:0] r_elem [MAX_COLS];
    logic signed [ELEM_W-1:0] r_diag [MAX_COLS];
    logic signed [ELEM_W-1:0] r_res;
    logic [ELEM_W-1:0]        r_w;
    logic [NORM_W-1:0]        r_norm;
    logic signed [ACC_W-1:0]  r_mat [MAX_COLS];

    logic signed [ELEM_W-1:0] in_elem [MAX_COLS];
    t_op                      lane_op [MAX_COLS];
    logic signed [ACC_W-1:0]  lane_mat [MAX_COLS];
    logic signed [ACC_W-1:0]  lane_rhs [MAX_COLS];
    logic signed [ACC_W-1:0]  rhs_sel;
    t_op                      norm_op;
    logic [NORM_W-1:0]        norm_mag;
    logic                     norm_neg;
    t_tag                     norm_tag;
    logic [NORM_W:0]          norm_sum;
    logic                     accept, emitting, sqrt_start, sqrt_done;
    logic [ROOT_W-1:0]        root;
    logic [CNT_W-1:0]         act_cols;
    logic                     damp_on;

    assign in_elem = '{i_elem_0, i_elem_1, i_elem_2, i_elem_3,
                       i_elem_4, i_elem_5, i_elem_6, i_elem_7};

    assign busy       = (r_state != S_IDLE);
    assign accept     = start && !busy;
    assign emitting   = (r_state == S_EMIT);
    assign sqrt_start = (r_state == S_DRAIN) && (r_drain == '0);
    assign damp_on    = r_last && (r_damping != '0);

    // Clamp columns in use to 1..MAX_COLS.
    always_comb begin
        if (r_cols_cfg == '0) act_cols = CNT_W'(1);
        else if (CNT_W'(r_cols_cfg) > CNT_W'(MAX_COLS)) act_cols = CNT_W'(MAX_COLS);
        else act_cols = CNT_W'(r_cols_cfg);
    end

    // Issue: lane j pairs its own column with the column of this step,
    // then with the residual, then squares its diagonal scale.
    always_comb begin
        for (int j = 0; j < MAX_COLS; j++) begin
            lane_op[j].a        = r_elem[j];
            lane_op[j].b        = r_elem[r_step[IDX_W-1:0]];
            lane_op[j].f        = r_w;
            lane_op[j].tag.sub  = 1'b0;
            lane_op[j].tag.addr = r_step[IDX_W-1:0];
            lane_op[j].tag.v    = (r_state == S_RUN) && (CNT_W'(j) < r_cols)
                                  && (CNT_W'(r_step) < r_cols);
            if (r_step == STEP_RHS) begin
                lane_op[j].b       = r_res;
                lane_op[j].tag.sub = 1'b1;
                lane_op[j].tag.v   = (r_state == S_RUN) && (CNT_W'(j) < r_cols);
            end else if (r_step == STEP_DAMP) begin
                lane_op[j].a        = r_diag[j];
                lane_op[j].b        = r_diag[j];
                lane_op[j].f        = r_damping;
                lane_op[j].tag.addr = IDX_W'(j);
                lane_op[j].tag.v    = (r_state == S_RUN) && (CNT_W'(j) < r_cols)
                                      && damp_on;
            end
        end
        norm_op.a        = r_res;
        norm_op.b        = r_res;
        norm_op.f        = r_w;
        norm_op.tag.sub  = 1'b0;
        norm_op.tag.addr = '0;
        norm_op.tag.v    = (r_state == S_RUN) && (r_step == STEP_RHS);
    end

    for (genvar g = 0; g < MAX_COLS; g++) begin : g_lane
        dwne_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (lane_op[g]),
            .i_clr   (emitting),
            .i_idx   (r_k),
            .o_mat   (lane_mat[g]),
            .o_rhs   (lane_rhs[g])
        );
    end

    dwne_mul u_norm_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (norm_op),
        .o_mag   (norm_mag),
        .o_neg   (norm_neg),
        .o_tag   (norm_tag)
    );

    dwne_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_val   (r_norm),
        .o_done  (sqrt_done),
        .o_root  (root)
    );

    assign norm_sum = {1'b0, r_norm} + {1'b0, norm_mag};
    assign rhs_sel  = lane_rhs[r_k];

    // Merge: the lanes give the matrix row, the selected lane the right side.
    assign o_mat_0 = r_mat[0];
    assign o_mat_1 = r_mat[1];
    assign o_mat_2 = r_mat[2];
    assign o_mat_3 = r_mat[3];
    assign o_mat_4 = r_mat[4];
    assign o_mat_5 = r_mat[5];
    assign o_mat_6 = r_mat[6];
    assign o_mat_7 = r_mat[7];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_step         <= '0;
            r_k            <= '0;
            r_drain        <= '0;
            r_damping      <= '0;
            r_cols_cfg     <= 4'(MAX_COLS);
            r_cols         <= CNT_W'(MAX_COLS);
            r_last         <= 1'b0;
            r_norm         <= '0;
            o_result_valid <= 1'b0;
            o_last         <= 1'b0;
            for (int i = 0; i < MAX_COLS; i++) r_diag[i] <= 32'sd65536;
        end else begin
            o_result_valid <= 1'b0;
            o_last         <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DAMPING: r_damping  <= i_cfg_data;
                    CFG_COLS:    r_cols_cfg <= i_cfg_data[3:0];
                    default:     r_damping  <= r_damping;
                endcase
            end
            // Add each weighted r^2 term, saturating at all ones.
            if (sqrt_start) r_norm <= '0;
            else if (norm_tag.v) r_norm <= norm_sum[NORM_W] ? '1 : norm_sum[NORM_W-1:0];

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_mode) begin
                            for (int i = 0; i < MAX_COLS; i++) r_diag[i] <= in_elem[i];
                        end else begin
                            r_state <= S_RUN;
                            r_step  <= '0;
                            r_cols  <= act_cols;
                            r_last  <= i_last_row;
                        end
                    end
                end
                S_RUN: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_DAMP) begin
                        r_drain <= 3'(DRAIN_CYC - 1);
                        r_state <= r_last ? S_DRAIN : S_IDLE;
                    end
                end
                S_DRAIN: begin
                    r_drain <= r_drain - 1'b1;
                    if (r_drain == '0) r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (sqrt_done) begin
                        r_state <= S_EMIT;
                        r_k     <= '0;
                    end
                end
                S_EMIT: begin
                    o_result_valid <= (CNT_W'(r_k) < r_cols);
                    o_last         <= (CNT_W'(r_k) == r_cols - 1'b1);
                    r_k            <= r_k + 1'b1;
                    if (r_k == IDX_W'(MAX_COLS - 1)) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
        if (accept && !i_mode) begin
            for (int i = 0; i < MAX_COLS; i++) r_elem[i] <= in_elem[i];
            r_res <= i_residual;
            r_w   <= i_weight;
        end
        for (int j = 0; j < MAX_COLS; j++) begin
            r_mat[j] <= (CNT_W'(j) < r_cols) ? lane_mat[j] : '0;
        end
        o_rhs_entry      <= rhs_sel;
        o_gradient_entry <= (rhs_sel == S48_MIN) ? S48_MAX : -rhs_sel;
        o_residual_norm  <= root;
    end

`ifndef ASSERT_OFF
    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state) == S_EMIT)
        else $error("result strobe outside the emission sweep");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_last |=> !o_result_valid)
        else $error("result after the final matrix row");
    a_row_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !i_mode |=> busy && r_state == S_RUN)
        else $error("accepted row did not start issue");
    a_root_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sqrt_done |-> r_state == S_ROOT)
        else $error("square root finished outside its wait state");
`endif

endmodule
`default_nettype wire

>>> rtl/dwne_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dwne_mul
// Three-stage weighted product: |a*b| * f >> 32 with the product sign.
// ----------------------------------------------------------------------------
module dwne_mul
    import dwne_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_op               i_op,
    output logic [NORM_W-1:0]      o_mag,
    output logic                   o_neg,
    output t_tag                   o_tag
);

    logic signed [2*ELEM_W-1:0] r_p;
    logic [ELEM_W-1:0]          r_f1;
    t_tag                       r_tag1, r_tag2;
    logic [2*ELEM_W-1:0]        r_ph, r_pl;
    logic                       r_neg2;
    logic [2*ELEM_W-1:0]        mag;
    logic signed [2*ELEM_W-1:0] prod;

    assign prod = i_op.a * i_op.b;
    assign mag  = r_p[2*ELEM_W-1] ? (2*ELEM_W)'(-r_p) : (2*ELEM_W)'(r_p);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            o_tag  <= '0;
        end else begin
            r_tag1 <= i_op.tag;
            r_tag2 <= r_tag1;
            o_tag  <= r_tag2;
        end
        // Hold the exact product, then split it into two 32x32 partials.
        r_p    <= prod;
        r_f1   <= i_op.f;
        r_ph   <= mag[2*ELEM_W-1:ELEM_W] * r_f1;
        r_pl   <= mag[ELEM_W-1:0] * r_f1;
        r_neg2 <= r_p[2*ELEM_W-1];
        o_mag  <= r_ph + {{ELEM_W{1'b0}}, r_pl[2*ELEM_W-1:ELEM_W]};
        o_neg  <= r_neg2;
    end

endmodule
`default_nettype wire

>>> rtl/dwne_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dwne_lane
// One column lane: weighted product pipeline, a column of matrix
// accumulators and the right-side accumulator of that column.
// ----------------------------------------------------------------------------
module dwne_lane
    import dwne_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_op                     i_op,
    input  wire logic                    i_clr,
    input  wire logic [IDX_W-1:0]        i_idx,
    output logic signed [ACC_W-1:0]      o_mat,
    output logic signed [ACC_W-1:0]      o_rhs
);

    logic [NORM_W-1:0]       mag;
    logic                    neg;
    t_tag                    mtag, r_ttag;
    logic signed [ACC_W-1:0] r_term;
    logic signed [ACC_W-1:0] r_acc [MAX_COLS];
    logic signed [ACC_W-1:0] r_rhs;

    dwne_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (i_op),
        .o_mag   (mag),
        .o_neg   (neg),
        .o_tag   (mtag)
    );

    assign o_mat = r_acc[i_idx];
    assign o_rhs = r_rhs;

    always_ff @(posedge i_clk) begin
        r_term <= sat_term(mag, neg);
        if (!i_rst_n) begin
            r_ttag <= '0;
            r_rhs  <= '0;
            for (int i = 0; i < MAX_COLS; i++) r_acc[i] <= '0;
        end else begin
            r_ttag <= mtag;
            if (r_ttag.v) begin
                if (r_ttag.sub) r_rhs <= add_sat(r_rhs, r_term, 1'b1);
                else r_acc[r_ttag.addr] <= add_sat(r_acc[r_ttag.addr], r_term, 1'b0);
            end
            // Drop each entry as it is read out.
            if (i_clr) begin
                r_acc[i_idx] <= '0;
                if (i_idx == IDX_W'(MAX_COLS - 1)) r_rhs <= '0;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/dwne_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dwne_sqrt
// Bit-serial integer square root of value * 2^16, one root bit a cycle.
// ----------------------------------------------------------------------------
module dwne_sqrt
    import dwne_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [NORM_W-1:0] i_val,
    output logic                   o_done,
    output logic [ROOT_W-1:0]      o_root
);

    localparam int X_W   = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 3;
    localparam int CW    = $clog2(ROOT_W);

    logic [X_W-1:0]   r_x;
    logic [REM_W-1:0] r_rem;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic [REM_W-1:0] rem_sh, trial;
    logic             ge;

    assign rem_sh = {r_rem[REM_W-3:0], r_x[X_W-1:X_W-2]};
    assign trial  = {1'b0, o_root, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(ROOT_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_x    <= {i_val, {(X_W-NORM_W){1'b0}}};
            r_rem  <= '0;
            o_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[X_W-3:0], 2'b00};
            r_rem  <= ge ? rem_sh - trial : rem_sh;
            o_root <= {o_root[ROOT_W-2:0], ge};
        end
    end

endmodule
`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the damped weighted normal-equation builder:
// streams directed and random Jacobian rows and diagonal loads, predicts
// every emitted matrix row and compares it field by field.
// ----------------------------------------------------------------------------
module testbench;
    import dwne_pkg::*;

    localparam logic MODE_ROW  = 1'b0;
    localparam logic MODE_DIAG = 1'b1;
    localparam int   SETTLE_CYC = 100;     // quiet cycles before a register write
    localparam int   CYCLE_LIMIT = 400000;

    typedef struct {
        bit                 is_cfg;
        logic               cfg_idx;
        logic [31:0]        cfg_data;
        logic               mode;
        logic signed [31:0] elem [8];
        logic signed [31:0] res;
        logic [31:0]        wt;
        logic               last_row;
    } t_pending;

    typedef struct {
        logic signed [47:0] mat [8];
        logic signed [47:0] rhs;
        logic signed [47:0] grad;
        logic [39:0]        norm;
        logic               last;
    } t_system_row;

    logic i_clk, i_rst_n;
    logic start, busy;
    logic i_cfg_we, i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic i_mode, i_last_row;
    logic signed [31:0] i_elem [8];
    logic signed [31:0] i_residual;
    logic [31:0] i_weight;
    logic o_result_valid, o_last;
    logic signed [47:0] o_mat [8];
    logic signed [47:0] o_rhs_entry, o_gradient_entry;
    logic [39:0] o_residual_norm;

    damped_weighted_normal_equations_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_mode(i_mode),
        .i_elem_0(i_elem[0]), .i_elem_1(i_elem[1]), .i_elem_2(i_elem[2]),
        .i_elem_3(i_elem[3]), .i_elem_4(i_elem[4]), .i_elem_5(i_elem[5]),
        .i_elem_6(i_elem[6]), .i_elem_7(i_elem[7]),
        .i_residual(i_residual), .i_weight(i_weight), .i_last_row(i_last_row),
        .o_result_valid(o_result_valid),
        .o_mat_0(o_mat[0]), .o_mat_1(o_mat[1]), .o_mat_2(o_mat[2]),
        .o_mat_3(o_mat[3]), .o_mat_4(o_mat[4]), .o_mat_5(o_mat[5]),
        .o_mat_6(o_mat[6]), .o_mat_7(o_mat[7]),
        .o_rhs_entry(o_rhs_entry), .o_gradient_entry(o_gradient_entry),
        .o_residual_norm(o_residual_norm), .o_last(o_last)
    );

    // Transactions waiting to be driven, and system rows waiting to come out.
    t_pending    pending_q[$];
    t_system_row system_rows_q[$];
    int          mismatches = 0;
    int unsigned cycle_count = 0;

    // Predictor state: upper triangle of the normal matrix, right side,
    // residual square sum, damping diagonal and the two registers.
    logic signed [47:0] nm_acc [8][8];
    logic signed [47:0] rhs_acc [8];
    logic [63:0]        rsq_acc;
    logic [31:0]        diag_vals [8];
    logic [31:0]        damp_reg;
    logic [3:0]         cols_reg;

    // ------------------------------------------------------------------
    // Fixed-point arithmetic of the block
    // ------------------------------------------------------------------
    // (a*b*f) >> 32 with the magnitude truncated, saturated to 48 bits
    function automatic logic signed [47:0] weighted_prod(logic signed [31:0] a,
                                                        logic signed [31:0] b,
                                                        logic [31:0] f);
        logic signed [63:0] aa, bb, p;
        logic [63:0] m;
        logic [95:0] s;
        logic signed [47:0] res;
        aa = a;
        bb = b;
        p  = aa * bb;
        m  = (p < 0) ? 64'(-p) : 64'(p);
        s  = ({32'b0, m} * {64'b0, f}) >> 32;
        if (p < 0) begin
            if (s > 96'h8000_0000_0000) res = S48_MIN;
            else res = -$signed(s[47:0]);
        end else begin
            if (s > 96'h7FFF_FFFF_FFFF) res = S48_MAX;
            else res = $signed(s[47:0]);
        end
        return res;
    endfunction

    function automatic logic signed [47:0] sat_add48(logic signed [47:0] a,
                                                     logic signed [47:0] b,
                                                     bit sub);
        logic signed [49:0] s;
        s = sub ? 50'(a) - 50'(b) : 50'(a) + 50'(b);
        if (s > 50'(S48_MAX)) return S48_MAX;
        if (s < 50'(S48_MIN)) return S48_MIN;
        return s[47:0];
    endfunction

    // floor(sqrt(acc * 2^16))
    function automatic logic [39:0] residual_root(logic [63:0] acc);
        logic [79:0] n;
        logic [39:0] y, c;
        n = {acc, 16'b0};
        y = '0;
        for (int b = 39; b >= 0; b--) begin
            c = y | (40'd1 << b);
            if ({40'b0, c} * {40'b0, c} <= n) y = c;
        end
        return y;
    endfunction

    function automatic int active_cols();
        if (cols_reg == 0) return 1;
        if (cols_reg > MAX_COLS) return MAX_COLS;
        return int'(cols_reg);
    endfunction

    function automatic void clear_sums();
        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 8; j++) nm_acc[i][j] = '0;
            rhs_acc[i] = '0;
        end
        rsq_acc = '0;
    endfunction

    // Fold one accepted transaction into the predictor; queue system rows on
    // the last row.
    function automatic void absorb_transaction(t_pending t);
        int cols;
        logic signed [63:0] rr;
        logic [95:0] nterm;
        logic [64:0] nsum;
        logic [39:0] root;
        t_system_row sr;
        cols = active_cols();
        if (t.mode == MODE_DIAG) begin
            for (int i = 0; i < 8; i++) diag_vals[i] = t.elem[i];
            return;
        end
        for (int i = 0; i < cols; i++) begin
            for (int j = i; j < cols; j++)
                nm_acc[i][j] = sat_add48(nm_acc[i][j],
                                         weighted_prod(t.elem[i], t.elem[j], t.wt), 0);
            rhs_acc[i] = sat_add48(rhs_acc[i], weighted_prod(t.elem[i], t.res, t.wt), 1);
        end
        rr = 64'(t.res) * 64'(t.res);
        nterm = ({32'b0, 64'(rr)} * {64'b0, t.wt}) >> 32;
        nsum = {1'b0, rsq_acc} + {1'b0, nterm[63:0]};
        rsq_acc = nsum[64] ? '1 : nsum[63:0];
        if (!t.last_row) return;
        if (damp_reg != 0)
            for (int i = 0; i < cols; i++)
                nm_acc[i][i] = sat_add48(nm_acc[i][i],
                                         weighted_prod(diag_vals[i], diag_vals[i], damp_reg), 0);
        root = residual_root(rsq_acc);
        for (int k = 0; k < cols; k++) begin
            for (int j = 0; j < 8; j++)
                sr.mat[j] = (j >= cols) ? 48'sd0 : (k <= j ? nm_acc[k][j] : nm_acc[j][k]);
            sr.rhs  = rhs_acc[k];
            sr.grad = sat_add48(48'sd0, rhs_acc[k], 1);
            sr.norm = root;
            sr.last = (k == cols - 1);
            system_rows_q.push_back(sr);
        end
        clear_sums();
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    function automatic logic [31:0] rand_q16();
        case ($urandom_range(0, 4))
            0, 1: return $urandom;
            2: return $urandom_range(0, 1) ? 32'($urandom_range(0, 4 << 16))
                                           : -32'($urandom_range(0, 4 << 16));
            3: return $urandom_range(0, 1) ? 32'($urandom_range(0, 1 << 22))
                                           : -32'($urandom_range(0, 1 << 22));
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    function automatic logic [31:0] rand_weight();
        case ($urandom_range(0, 3))
            0: return 32'h0001_0000;
            1: return $urandom;
            2: return $urandom_range(0, 1 << 18);
            default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        endcase
    endfunction

    function automatic void add_cfg(logic idx, logic [31:0] data);
        t_pending t;
        t.is_cfg = 1;
        t.cfg_idx = idx;
        t.cfg_data = data;
        t.mode = MODE_ROW;
        for (int i = 0; i < 8; i++) t.elem[i] = '0;
        t.res = '0;
        t.wt = '0;
        t.last_row = 0;
        pending_q.push_back(t);
    endfunction

    // Every element equal to e; used for the directed extremes.
    function automatic void add_fill(logic mode, logic [31:0] e, logic [31:0] r,
                                     logic [31:0] w, logic last);
        t_pending t;
        t.is_cfg = 0;
        t.cfg_idx = CFG_DAMPING;
        t.cfg_data = '0;
        t.mode = mode;
        for (int i = 0; i < 8; i++) t.elem[i] = e;
        t.res = r;
        t.wt = w;
        t.last_row = last;
        pending_q.push_back(t);
    endfunction

    function automatic void add_random(logic mode, logic last);
        t_pending t;
        t.is_cfg = 0;
        t.cfg_idx = CFG_DAMPING;
        t.cfg_data = '0;
        t.mode = mode;
        for (int i = 0; i < 8; i++) t.elem[i] = rand_q16();
        t.res = rand_q16();
        t.wt = rand_weight();
        t.last_row = last;
        pending_q.push_back(t);
    endfunction

    function automatic logic [31:0] rand_damping();
        case ($urandom_range(0, 4))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 1 << 17);
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset and stimulus
    // ------------------------------------------------------------------
    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        int n_items;
        i_rst_n = 0;
        // Directed: default registers first, diagonal untouched.
        add_fill(MODE_ROW, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0);
        add_fill(MODE_ROW, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
        add_fill(MODE_ROW, 32'h0001_0000, 32'h0002_0000, 32'h0, 0);
        add_fill(MODE_ROW, 32'hFFFF_0000, 32'h0003_0000, 32'h0001_0000, 1);
        // Diagonal load with the most negative value; last_row ignored.
        add_fill(MODE_DIAG, 32'h8000_0000, 32'h0, 32'h0, 1);
        add_cfg(CFG_DAMPING, 32'hFFFF_FFFF);
        add_fill(MODE_ROW, 32'h0002_0000, 32'hFFFF_8000, 32'h0001_0000, 1);
        add_fill(MODE_DIAG, 32'hFFFE_0000, 32'h0, 32'h0, 0);
        add_cfg(CFG_DAMPING, 32'h0000_8000);
        add_cfg(CFG_COLS, 32'hFFFF_FFF1);
        add_fill(MODE_ROW, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
        add_fill(MODE_ROW, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1);
        // Zero columns behaves as one, above the maximum as the maximum.
        add_cfg(CFG_COLS, 32'h0);
        add_fill(MODE_ROW, 32'h8000_0000, 32'h8000_0000, 32'h0001_0000, 1);
        add_cfg(CFG_COLS, 32'hF);
        add_cfg(CFG_DAMPING, 32'h0);
        add_fill(MODE_ROW, 32'h0001_0000, 32'h0, 32'h0001_0000, 1);
        add_cfg(CFG_COLS, 32'd3);
        add_cfg(CFG_DAMPING, 32'h0001_0000);
        add_fill(MODE_DIAG, 32'h0, 32'h0, 32'h0, 0);
        add_random(MODE_ROW, 0);
        add_random(MODE_ROW, 1);

        // Random: register settings, then well-formed row streams.
        n_items = 0;
        while (n_items < 220) begin
            int rows;
            if ($urandom_range(0, 2) != 0) add_cfg(CFG_DAMPING, rand_damping());
            if ($urandom_range(0, 2) != 0)
                add_cfg(CFG_COLS, ($urandom_range(0, 9) == 0) ? $urandom
                                                               : 32'($urandom_range(1, 8)));
            if ($urandom_range(0, 3) == 0) begin
                add_random(MODE_DIAG, 1'($urandom_range(0, 1)));
                n_items++;
            end
            rows = $urandom_range(1, 6);
            for (int r = 0; r < rows; r++) begin
                // Occasionally change the column count mid-stream.
                if (r > 0 && $urandom_range(0, 9) == 0)
                    add_cfg(CFG_COLS, 32'($urandom_range(1, 8)));
                add_random(MODE_ROW, r == rows - 1);
                n_items++;
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;

        while (pending_q.size() != 0 || start) @(posedge i_clk);
        while (system_rows_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: bursts of transactions with random gaps; register writes
    // only once the block has gone quiet.
    // ------------------------------------------------------------------
    int burst_left = 4;
    int gap_left = 0;
    int quiet = 0;

    initial begin
        start = 0;
        i_cfg_we = 0;
        i_cfg_idx = CFG_DAMPING;
        i_cfg_data = '0;
        i_mode = MODE_ROW;
        for (int i = 0; i < 8; i++) i_elem[i] = '0;
        i_residual = '0;
        i_weight = '0;
        i_last_row = 0;
    end

    always @(posedge i_clk) begin
        bit go, we;
        t_pending t;
        if (!i_rst_n) begin
            damp_reg = '0;
            cols_reg = 4'd8;
            for (int i = 0; i < 8; i++) diag_vals[i] = 32'h0001_0000;
            clear_sums();
        end else begin
            // Retire the transaction taken at this edge.
            if (start && !busy) absorb_transaction(pending_q.pop_front());
            if (start || busy || o_result_valid || system_rows_q.size() != 0) quiet = 0;
            else if (quiet < SETTLE_CYC) quiet++;

            go = start && busy;      // hold a transaction not yet taken
            we = 0;
            if (!go && pending_q.size() != 0) begin
                t = pending_q[0];
                if (t.is_cfg) begin
                    // Write only when nothing is in flight.
                    if (!start && quiet >= SETTLE_CYC) begin
                        we = 1;
                        i_cfg_idx  <= t.cfg_idx;
                        i_cfg_data <= t.cfg_data;
                        if (t.cfg_idx == CFG_DAMPING) damp_reg = t.cfg_data;
                        else cols_reg = t.cfg_data[3:0];
                        void'(pending_q.pop_front());
                    end
                end else if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    go = 1;
                    i_mode     <= t.mode;
                    i_elem     <= t.elem;
                    i_residual <= t.res;
                    i_weight   <= t.wt;
                    i_last_row <= t.last_row;
                    if (--burst_left <= 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 30);
                    end
                end
            end
            start    <= go;
            i_cfg_we <= we;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every strobed result against the oldest expected system row.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_system_row e;
        bit bad;
        if (i_rst_n && o_result_valid) begin
            if (system_rows_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result, mat_0=%h", o_mat[0]);
            end else begin
                e = system_rows_q.pop_front();
                bad = (o_rhs_entry !== e.rhs) || (o_gradient_entry !== e.grad) ||
                      (o_residual_norm !== e.norm) || (o_last !== e.last);
                for (int j = 0; j < 8; j++) if (o_mat[j] !== e.mat[j]) bad = 1;
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at cycle %0d", cycle_count);
                        for (int j = 0; j < 8; j++)
                            $display("  mat_%0d exp %h got %h", j, e.mat[j], o_mat[j]);
                        $display("  rhs exp %h got %h, grad exp %h got %h",
                                 e.rhs, o_rhs_entry, e.grad, o_gradient_entry);
                        $display("  norm exp %h got %h, last exp %b got %b",
                                 e.norm, o_residual_norm, e.last, o_last);
                    end
                end
            end
        end
    end

    // Drop the run if it hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule
